// ----- design/ptt_pkg.sv -----
// Shared types, codes and reset constants for the periodic timer table.
// No dependencies; imported by every module of the block.
package ptt_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TPS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_CH  = 2'd2;

    localparam logic [15:0] TPS_RESET      = 16'd1000;
    localparam logic [15:0] FINE_THR_RESET = 16'd100;
    localparam logic [5:0]  FINE_CH_RESET  = 6'd0;

    localparam logic [2:0] OP_SET         = 3'd0;
    localparam logic [2:0] OP_KILL        = 3'd1;
    localparam logic [2:0] OP_RESTART     = 3'd2;
    localparam logic [2:0] OP_QUERY       = 3'd3;
    localparam logic [2:0] OP_RESTART_ALL = 3'd4;
    localparam logic [2:0] OP_TICK        = 3'd5;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  timer_id;
        logic [15:0] period_seconds;
        logic [31:0] tag;
    } s_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  fired_id;
        logic [31:0] fired_tag;
        logic        active;
        logic        bad_id;
        logic        last;
    } m_result_t;

    typedef struct packed {
        logic [15:0] period;
        logic [31:0] tag;
        logic [15:0] sub;
        logic [15:0] sec;
    } timer_entry_t;

    typedef struct packed {
        logic [15:0] tps;
        logic [15:0] fine_thr;
        logic [5:0]  fine_ch;
    } cfg_t;

    typedef struct packed {
        timer_entry_t entry;
        logic         fire;
        logic         status_hit;
        m_result_t    expiry;
        m_result_t    status;
    } head_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- design/ptt_cell.sv -----
// One slot of the timer ring: holds one timer entry and passes it on.
// Depends on ptt_pkg for the entry type.
module ptt_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  ptt_pkg::timer_entry_t d_in,
    output ptt_pkg::timer_entry_t q_out
);
    import ptt_pkg::*;

    timer_entry_t entry_reg;
    timer_entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (shift_en) begin
            entry_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign q_out = entry_reg;

endmodule

// ----- design/ptt_head.sv -----
// Update cell at the head of the timer ring: applies the current item to the
// entry passing by and forms its expiry and status results. Uses ptt_pkg.
module ptt_head #(
    parameter  int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  ptt_pkg::timer_entry_t entry_in,
    input  ptt_pkg::s_item_t      item,
    input  ptt_pkg::cfg_t         cfg,
    input  logic [IDX_W-1:0]      step,
    output ptt_pkg::head_out_t    head_out
);
    import ptt_pkg::*;

    logic [5:0]   step_id;
    logic         hit;
    logic         is_active;
    logic         is_fine;
    logic [15:0]  tps_eff;
    logic [16:0]  sub_inc;
    logic         roll;
    logic [15:0]  sub_new;
    logic [15:0]  sec_new;
    logic         fire_now;
    timer_entry_t e;
    logic         fire;

    assign step_id   = 6'(step);
    assign hit       = (item.timer_id == step_id);
    assign is_active = (entry_in.period != 16'd0);
    assign is_fine   = (cfg.fine_ch == step_id);
    assign tps_eff   = (cfg.tps == 16'd0) ? 16'd1 : cfg.tps;
    assign sub_inc   = {1'b0, entry_in.sub} + 17'd1;
    assign roll      = (sub_inc >= {1'b0, tps_eff});
    assign sub_new   = roll ? 16'd0 : sub_inc[15:0];
    assign sec_new   = (roll && (entry_in.sec != 16'hFFFF)) ? entry_in.sec + 16'd1
                                                            : entry_in.sec;
    assign fire_now  = is_fine ? (sub_new > cfg.fine_thr) : (sec_new >= entry_in.period);

    always_comb begin
        e    = entry_in;
        fire = 1'b0;
        unique case (item.op)
            OP_SET: begin
                if (hit) begin
                    e.period = item.period_seconds;
                    e.tag    = item.tag;
                    e.sub    = 16'd0;
                    e.sec    = 16'd0;
                end
            end
            OP_KILL: begin
                if (hit) begin
                    e.period = 16'd0;
                    e.tag    = 32'd0;
                end
            end
            OP_RESTART: begin
                if (hit) begin
                    e.sub = 16'd0;
                    e.sec = 16'd0;
                end
            end
            OP_QUERY: begin
            end
            OP_RESTART_ALL: begin
                if (is_active) begin
                    e.sub = 16'd0;
                    e.sec = 16'd0;
                end
            end
            OP_TICK: begin
                if (is_active) begin
                    fire = fire_now;
                    if (fire_now) begin
                        e.sub = 16'd0;
                        e.sec = 16'd0;
                    end else begin
                        e.sub = sub_new;
                        e.sec = sec_new;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        head_out.entry      = e;
        head_out.fire       = fire;
        head_out.status_hit = hit && (item.op <= OP_QUERY);

        head_out.expiry.kind      = KIND_EXPIRY;
        head_out.expiry.fired_id  = step_id;
        head_out.expiry.fired_tag = entry_in.tag;
        head_out.expiry.active    = 1'b1;
        head_out.expiry.bad_id    = 1'b0;
        head_out.expiry.last      = 1'b0;

        head_out.status.kind      = KIND_STATUS;
        head_out.status.fired_id  = step_id;
        head_out.status.fired_tag = e.tag;
        head_out.status.active    = (e.period != 16'd0);
        head_out.status.bad_id    = 1'b0;
        head_out.status.last      = 1'b1;
    end

endmodule

// ----- design/periodic_timer_table.sv -----
// Top level of the periodic timer table: ring of timer cells, head update cell,
// control sequencer, configuration registers and output register. Uses ptt_pkg.
//
// The timer entries sit in a ring of NUM_TIMERS cells that rotates one step per
// cycle past a single update cell while an item is scanned, holding while an
// expiry waits for m_ready. An accepted command or tick is taken in ST_IDLE, then
// the ring makes one full turn in ST_SCAN and ST_FINISH hands over the final
// result (status or end-of-tick marker), waiting for m_ready while the output
// register is full. A command with an out-of-range timer id skips the turn and
// goes straight to ST_FINISH; an unused op code is dropped with no result.
// Results leave through a single output register, so the block may take the next
// item while the last result of the previous one is still waiting.
module periodic_timer_table #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ptt_pkg::s_item_t                  s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ptt_pkg::m_result_t                m_result
);
    import ptt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_TIMERS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    s_item_t          item_reg, item_next;
    cfg_t             cfg_reg, cfg_next;
    m_result_t        fin_reg, fin_next;
    logic             m_valid_reg, m_valid_next;
    m_result_t        m_result_reg, m_result_next;

    timer_entry_t     cell_q [NUM_TIMERS];
    head_out_t        head_out;

    logic             in_accept;
    logic             out_free;
    logic             bad_cmd;
    logic             advance;
    logic             exp_load;
    logic             fin_load;
    logic             scan_done;

    // ring: each cell takes from its upper neighbor, the top cell from the head
    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
            timer_entry_t d_in;
            if (gi == NUM_TIMERS - 1) begin : g_top
                assign d_in = head_out.entry;
            end else begin : g_mid
                assign d_in = cell_q[gi + 1];
            end
            ptt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (advance),
                .d_in     (d_in),
                .q_out    (cell_q[gi])
            );
        end
    endgenerate

    ptt_head #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_head (
        .entry_in (cell_q[0]),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .step     (step_reg),
        .head_out (head_out)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign bad_cmd   = (s_item.op <= OP_QUERY) && (s_item.timer_id >= 6'(NUM_TIMERS));
    assign scan_done = (step_reg == LAST_STEP);

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        advance  = 1'b0;
        exp_load = 1'b0;
        fin_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                advance  = !head_out.fire || out_free;
                exp_load = head_out.fire && out_free;
            end
            ST_FINISH: begin
                fin_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    priority if (s_item.op > OP_TICK) begin
                        state_next = ST_IDLE;
                    end else if (bad_cmd) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (advance && scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (in_accept) begin
            step_next = '0;
        end else if (advance) begin
            step_next = scan_done ? '0 : step_reg + 1'b1;
        end
    end

    assign item_next = in_accept ? s_item : item_reg;

    always_comb begin
        fin_next = fin_reg;
        if (in_accept) begin
            fin_next.kind      = (s_item.op == OP_TICK) ? KIND_END : KIND_STATUS;
            fin_next.fired_id  = bad_cmd ? s_item.timer_id : 6'd0;
            fin_next.fired_tag = 32'd0;
            fin_next.active    = 1'b0;
            fin_next.bad_id    = bad_cmd;
            fin_next.last      = 1'b1;
        end else if (advance && head_out.status_hit) begin
            fin_next = head_out.status;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TPS:      cfg_next.tps      = cfg_wdata;
                CFG_FINE_THR: cfg_next.fine_thr = cfg_wdata;
                CFG_FINE_CH:  cfg_next.fine_ch  = cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        priority if (exp_load) begin
            m_valid_next  = 1'b1;
            m_result_next = head_out.expiry;
        end else if (fin_load) begin
            m_valid_next  = 1'b1;
            m_result_next = fin_reg;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            cfg_reg     <= '{tps: TPS_RESET, fine_thr: FINE_THR_RESET,
                             fine_ch: FINE_CH_RESET};
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        fin_reg      <= fin_next;
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_stall_holds_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && head_out.fire && m_valid_reg && !m_ready)
        |=> $stable(step_reg) && state_reg == ST_SCAN)
        else $error("ring advanced while an expiry was blocked");

    a_ring_realigned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_FINISH) |=> step_reg == '0)
        else $error("ring not back in place after a full turn");

    a_expiry_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_load |=> m_valid && m_result.kind == KIND_EXPIRY && !m_result.last)
        else $error("expiry result malformed");

    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_load |=> m_valid && m_result.last && state_reg == ST_IDLE)
        else $error("final result not marked last");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for periodic_timer_table: directed and random commands and ticks, with
// results predicted in a scoreboard class and checked in order. Uses ptt_pkg.
module tb_top;
    import ptt_pkg::*;

    localparam int NUM_TIMERS    = NUM_TIMERS_DEF;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int LONG_HOLD     = 400;

    class timer_scoreboard;
        logic [15:0] period_q [NUM_TIMERS_DEF];
        logic [31:0] tag_q    [NUM_TIMERS_DEF];
        logic [15:0] sub_q    [NUM_TIMERS_DEF];
        logic [15:0] sec_q    [NUM_TIMERS_DEF];
        logic [15:0] tps;
        logic [15:0] fine_thr;
        logic [5:0]  fine_ch;
        m_result_t   expected_results [$];
        int          fails;

        function new();
            tps      = TPS_RESET;
            fine_thr = FINE_THR_RESET;
            fine_ch  = FINE_CH_RESET;
            fails    = 0;
            foreach (period_q[i]) begin
                period_q[i] = '0;
                tag_q[i]    = '0;
                sub_q[i]    = '0;
                sec_q[i]    = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TPS:      tps = val;
                CFG_FINE_THR: fine_thr = val;
                CFG_FINE_CH:  fine_ch = val[5:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [5:0] id, logic [31:0] tag,
                                  logic act, logic bad, logic fin);
            m_result_t r;
            r.kind      = kind;
            r.fired_id  = id;
            r.fired_tag = tag;
            r.active    = act;
            r.bad_id    = bad;
            r.last      = fin;
            expected_results.push_back(r);
        endfunction

        function void predict_results(s_item_t it);
            int  tps_eff;
            int  sub;
            logic fire;
            logic [5:0] id;
            id = it.timer_id;
            case (it.op)
                OP_SET, OP_KILL, OP_RESTART, OP_QUERY: begin
                    if (id >= NUM_TIMERS_DEF) begin
                        push_result(KIND_STATUS, id, '0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        case (it.op)
                            OP_SET: begin
                                period_q[id] = it.period_seconds;
                                tag_q[id]    = it.tag;
                                sub_q[id]    = '0;
                                sec_q[id]    = '0;
                            end
                            OP_KILL: begin
                                period_q[id] = '0;
                                tag_q[id]    = '0;
                            end
                            OP_RESTART: begin
                                sub_q[id] = '0;
                                sec_q[id] = '0;
                            end
                            default: ;
                        endcase
                        push_result(KIND_STATUS, id, tag_q[id], period_q[id] != 0, 1'b0, 1'b1);
                    end
                end
                OP_RESTART_ALL: begin
                    foreach (period_q[i]) begin
                        if (period_q[i] != 0) begin
                            sub_q[i] = '0;
                            sec_q[i] = '0;
                        end
                    end
                    push_result(KIND_STATUS, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                OP_TICK: begin
                    tps_eff = (tps == 0) ? 1 : int'(tps);
                    for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
                        if (period_q[i] != 0) begin
                            sub = int'(sub_q[i]) + 1;
                            if (sub >= tps_eff) begin
                                sub = 0;
                                if (sec_q[i] != 16'hFFFF)
                                    sec_q[i] = sec_q[i] + 16'd1;
                            end
                            sub_q[i] = sub[15:0];
                            if (i == int'(fine_ch))
                                fire = sub > int'(fine_thr);
                            else
                                fire = sec_q[i] >= period_q[i];
                            if (fire) begin
                                sub_q[i] = '0;
                                sec_q[i] = '0;
                                push_result(KIND_EXPIRY, i[5:0], tag_q[i], 1'b1, 1'b0, 1'b0);
                            end
                        end
                    end
                    push_result(KIND_END, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        task flag_mismatch(string msg);
            if (fails < 40)
                $display("MISMATCH: %s", msg);
            fails++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(m_result_t got);
            m_result_t want;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("fired_id", got.fired_id, want.fired_id);
            compare_field("fired_tag", got.fired_tag, want.fired_tag);
            compare_field("active", got.active, want.active);
            compare_field("bad_id", got.bad_id, want.bad_id);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TPS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    s_item_t               s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    m_result_t             m_result;

    int send_idle_pct   = 11;
    int recv_idle_pct   = 81;
    int rx_hold_request = 0;
    int rx_hold_left    = 0;
    int quiet_cycles    = 0;

    timer_scoreboard sb = new();

    periodic_timer_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_result(m_result);
        if (rx_hold_request > 0) begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic pause_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_done();
        pause_input();
        while (sb.expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] tps, input logic [15:0] thr,
                             input logic [5:0] ch);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TPS;
        cfg_wdata <= tps;
        @(posedge aclk);
        sb.write_reg(CFG_TPS, tps);
        cfg_index <= CFG_FINE_THR;
        cfg_wdata <= thr;
        @(posedge aclk);
        sb.write_reg(CFG_FINE_THR, thr);
        cfg_index <= CFG_FINE_CH;
        cfg_wdata <= {10'd0, ch};
        @(posedge aclk);
        sb.write_reg(CFG_FINE_CH, {10'd0, ch});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input s_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.predict_results(it);
    endtask

    function automatic s_item_t random_item();
        s_item_t it;
        int      r;
        int      pick;
        it.tag            = $urandom;
        it.period_seconds = 16'($urandom_range(16'hFFFF));
        it.timer_id = ($urandom_range(99) < 8) ? 6'($urandom_range(63, NUM_TIMERS))
                                               : 6'($urandom_range(NUM_TIMERS - 1));
        r = $urandom_range(99);
        if (r < 40) begin
            it.op = OP_TICK;
        end else if (r < 62) begin
            it.op = OP_SET;
            pick = $urandom_range(99);
            if (pick < 70)
                it.period_seconds = 16'($urandom_range(3, 1));
            else if (pick < 80)
                it.period_seconds = '0;
        end else if (r < 70) begin
            it.op = OP_KILL;
        end else if (r < 78) begin
            it.op = OP_RESTART;
        end else if (r < 86) begin
            it.op = OP_QUERY;
        end else if (r < 92) begin
            it.op = OP_RESTART_ALL;
        end else begin
            it.op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return it;
    endfunction

    task automatic run_phase(input int n_items, input bit hold_rx, input bit drain_midway);
        s_item_t it;
        int      done;
        bit      mid_taken;
        done = 0;
        mid_taken = 1'b0;
        while (done < n_items) begin
            if (!mid_taken && done >= n_items / 2) begin
                mid_taken = 1'b1;
                if (hold_rx)
                    rx_hold_request = LONG_HOLD;
                if (drain_midway)
                    wait_results_done();
            end
            it = random_item();
            send_item(it);
            if (it.op <= OP_TICK)
                done++;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        configure(16'd2, 16'd0, 6'd3);
        send_item(s_item_t'{OP_SET, 6'd0, 16'd1, 32'hFFFF_FFFF});
        send_item(s_item_t'{OP_SET, 6'd15, 16'hFFFF, 32'h0000_0000});
        send_item(s_item_t'{OP_SET, 6'd3, 16'd1, 32'h0000_A5A5});
        send_item(s_item_t'{OP_SET, 6'd7, 16'd0, 32'h1234_5678});
        send_item(s_item_t'{OP_SET, 6'd63, 16'd5, 32'hDEAD_BEEF});
        send_item(s_item_t'{OP_KILL, 6'd16, 16'd0, 32'h0});
        send_item(s_item_t'{OP_QUERY, 6'd5, 16'd0, 32'h0});
        send_item(s_item_t'{OP_RESTART, 6'd2, 16'd0, 32'h0});
        repeat (4) send_item(s_item_t'{OP_TICK, 6'd0, 16'd0, 32'h0});
        send_item(s_item_t'{OP_RESTART, 6'd0, 16'd0, 32'h0});
        send_item(s_item_t'{OP_RESTART_ALL, 6'd9, 16'd0, 32'h0});
        send_item(s_item_t'{OP_TICK, 6'd0, 16'd0, 32'h0});
        send_item(s_item_t'{OP_KILL, 6'd15, 16'd0, 32'h0});
        send_item(s_item_t'{OP_QUERY, 6'd15, 16'd0, 32'h0});
        send_item(s_item_t'{OP_QUERY, 6'd0, 16'd0, 32'h0});
        send_item(s_item_t'{OP_SPARE_6, 6'd63, 16'hFFFF, 32'hFFFF_FFFF});
        send_item(s_item_t'{OP_SPARE_7, 6'd0, 16'd0, 32'h0});
        send_item(s_item_t'{OP_TICK, 6'd63, 16'hFFFF, 32'hFFFF_FFFF});
        send_item(s_item_t'{OP_SET, 6'd15, 16'd2, 32'h5555_5555});
        repeat (2) send_item(s_item_t'{OP_TICK, 6'd0, 16'd0, 32'h0});

        configure(16'd1, 16'd0, 6'd0);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        configure(16'd0, 16'hFFFF, 6'd63);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        send_idle_pct = 81;
        recv_idle_pct = 11;
        configure(16'd3, 16'd1, 6'd5);
        run_phase(PHASE_ITEMS, 1'b0, 1'b1);
        configure(16'hFFFF, 16'd0, 6'd2);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'($urandom_range(4, 1)), 16'($urandom_range(3)),
                  6'($urandom_range(17)));
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        configure(16'd2, 16'd0, 6'd10);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ptt_pkg.sv
design/ptt_cell.sv
design/ptt_head.sv
design/periodic_timer_table.sv
verif/tb_top.sv
